FILE: rtl/core/apiv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apiv_pkg
// Shared types, constants and helpers of the audio pack index validator.
// ----------------------------------------------------------------------------
package apiv_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int ENTRY_BYTES  = 76;
    localparam int MAX_ENTRIES  = 64;
    localparam int KEY_BYTES    = 64;
    localparam int KEY_WORDS    = (KEY_BYTES + 7) / 8;
    localparam int KW_BITS      = $clog2(KEY_WORDS);
    localparam int ENT_BITS     = $clog2(MAX_ENTRIES);
    localparam int KEY_AW       = ENT_BITS + KW_BITS;

    localparam logic [16:0] COMP_MIN = 17'd18;
    localparam logic [16:0] COMP_MAX = 17'd66560;
    localparam logic [16:0] DEC_MIN  = 17'd12;
    localparam logic [16:0] DEC_MAX  = 17'd65536;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_LEN_SHORT = 4'd1,
        ST_LEN_LONG  = 4'd2,
        ST_MAGIC     = 4'd3,
        ST_COUNT     = 4'd4,
        ST_INDEX_FIT = 4'd5,
        ST_KEY_EMPTY = 4'd6,
        ST_KEY_CHAR  = 4'd7,
        ST_KEY_PAD   = 4'd8,
        ST_KEY_DUP   = 4'd9,
        ST_OFFSET    = 4'd10,
        ST_COMP_LEN  = 4'd11,
        ST_DEC_LEN   = 4'd12,
        ST_COMP_FIT  = 4'd13,
        ST_TOTAL     = 4'd14,
        ST_TRUNC     = 4'd15
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HDR  = 2'd1,
        PH_ENT  = 2'd2
    } t_phase;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } t_state;

    typedef enum logic [0:0] {
        CFG_PACK_LENGTH = 1'b0,
        CFG_MAX_PACK    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_pack;
        logic       end_of_data;
    } t_in;

    typedef struct packed {
        logic          result_kind;
        t_status       status;
        logic [5:0]    entry_number;
        logic [31:0]   data_offset;
        logic [16:0]   compressed_length;
        logic [16:0]   decoded_length;
        logic [6:0]    entry_count;
    } t_out;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic [63:0]       data;
    } t_kwr;

    typedef struct packed {
        logic done;
        logic dup;
    } t_srch;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h50;
            3'd1:    v = 8'h44;
            3'd2:    v = 8'h41;
            3'd3:    v = 8'h55;
            3'd4:    v = 8'h44;
            3'd5:    v = 8'h49;
            3'd6:    v = 8'h4F;
            3'd7:    v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/apiv_key_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apiv_key_search
// Key store with two read ports and a word-serial duplicate key search.
// ----------------------------------------------------------------------------
module apiv_key_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  apiv_pkg::t_kwr                 i_wr,
    input  logic                           i_start,
    input  logic [apiv_pkg::ENT_BITS-1:0]  i_cur,
    output apiv_pkg::t_srch                o_res
);
    import apiv_pkg::*;

    logic [63:0]         mem [1 << KEY_AW];
    logic [63:0]         r_da;
    logic [63:0]         r_db;
    logic                r_busy, n_busy;
    logic                r_iss, n_iss;
    logic [ENT_BITS-1:0] r_j, n_j;
    logic [KW_BITS-1:0]  r_w, n_w;
    logic                r_cv, n_cv;
    logic                r_clast, n_clast;
    logic                r_cend, n_cend;
    logic                r_same, n_same;
    logic                r_done, n_done;
    logic                r_dup, n_dup;
    logic                eq;
    logic                w_last;
    logic                j_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (r_iss) begin
            r_da <= mem[{r_j, r_w}];
            r_db <= mem[{i_cur, r_w}];
        end
    end

    assign w_last = (r_w == KW_BITS'(KEY_WORDS - 1));
    assign j_last = (r_j == i_cur - ENT_BITS'(1));
    assign eq     = r_same && (r_da == r_db);

    always_comb begin
        n_busy  = r_busy;
        n_iss   = r_iss;
        n_j     = r_j;
        n_w     = r_w;
        n_cv    = r_cv;
        n_clast = r_clast;
        n_cend  = r_cend;
        n_same  = r_same;
        n_done  = 1'b0;
        n_dup   = 1'b0;
        if (i_start) begin
            if (i_cur == '0) begin
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_iss  = 1'b1;
                n_j    = '0;
                n_w    = '0;
                n_same = 1'b1;
                n_cv   = 1'b0;
            end
        end else if (r_busy) begin
            n_cv    = r_iss;
            n_clast = w_last;
            n_cend  = w_last && j_last;
            if (r_iss) begin
                n_w = r_w + KW_BITS'(1);
                if (w_last) begin
                    n_j = r_j + ENT_BITS'(1);
                    if (j_last) begin
                        n_iss = 1'b0;
                    end
                end
            end
            if (r_cv) begin
                if (r_clast) begin
                    if (eq) begin
                        n_done = 1'b1;
                        n_dup  = 1'b1;
                        n_busy = 1'b0;
                        n_iss  = 1'b0;
                        n_cv   = 1'b0;
                    end else if (r_cend) begin
                        n_done = 1'b1;
                        n_busy = 1'b0;
                        n_cv   = 1'b0;
                    end else begin
                        n_same = 1'b1;
                    end
                end else begin
                    n_same = eq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_iss   <= 1'b0;
            r_cv    <= 1'b0;
            r_done  <= 1'b0;
            r_dup   <= 1'b0;
            r_j     <= '0;
            r_w     <= '0;
            r_clast <= 1'b0;
            r_cend  <= 1'b0;
            r_same  <= 1'b1;
        end else begin
            r_busy  <= n_busy;
            r_iss   <= n_iss;
            r_cv    <= n_cv;
            r_done  <= n_done;
            r_dup   <= n_dup;
            r_j     <= n_j;
            r_w     <= n_w;
            r_clast <= n_clast;
            r_cend  <= n_cend;
            r_same  <= n_same;
        end
    end

    assign o_res.done = r_done;
    assign o_res.dup  = r_dup;

endmodule

FILE: rtl/core/audio_pack_index_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_pack_index_validator
// Checks a pack header and index byte by byte; emits entry records and a verdict.
// ----------------------------------------------------------------------------
// One beat carries one byte. Most bytes are taken back to back: the block stays
// ready for the next byte unless results are still queued. The last byte of an
// index entry starts a word-serial duplicate key search over the stored keys
// through a dual-read key memory: the last byte of entry n holds off the next
// byte until the search ends, which compares one 64-bit word per cycle and ends
// early when a duplicate turns up. Results pass through a two-deep queue and an
// output register; a byte that yields results is followed by no new byte until
// the queue has moved into the output register.
module audio_pack_index_validator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  apiv_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output apiv_pkg::t_out   o_out_data,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_wdata
);
    import apiv_pkg::*;

    t_state       r_state, n_state;
    t_phase       r_phase, n_phase;
    logic [7:0]   r_pos, n_pos;
    logic [6:0]   r_exp, n_exp;
    logic [6:0]   r_cur, n_cur;
    logic [32:0]  r_nxo, n_nxo;
    logic [31:0]  r_fld, n_fld;
    logic [63:0]  r_kword, n_kword;
    logic         r_kterm, n_kterm;
    t_status      r_kpend, n_kpend;
    logic         r_hdr_bad, n_hdr_bad;
    logic         r_off_ok, n_off_ok;
    logic [16:0]  r_comp, n_comp;
    logic [16:0]  r_dec, n_dec;
    logic         r_eod, n_eod;
    logic [1:0]   r_qv, n_qv;
    t_out         r_q0, n_q0;
    t_out         r_q1, n_q1;
    logic         r_ov;
    t_out         r_out;
    logic [31:0]  r_pack_len;
    logic [31:0]  r_max_len;

    t_kwr         kwr;
    t_srch        srch;
    logic         srch_start;
    logic         in_acc;
    logic         q_move;
    logic [7:0]   b;
    logic [31:0]  fld_byte;
    logic [33:0]  fit_sum;

    function automatic t_out mk_verdict(input t_status code, input logic [6:0] cnt);
        t_out v;
        v              = '0;
        v.result_kind  = 1'b1;
        v.status       = code;
        v.entry_count  = (code == ST_OK) ? cnt : 7'd0;
        return v;
    endfunction

    function automatic logic key_char_ok(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h30) && (c <= 8'h39))
            || (c == 8'h5F);
    endfunction

    apiv_key_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (kwr),
        .i_start (srch_start),
        .i_cur   (r_cur[ENT_BITS-1:0]),
        .o_res   (srch)
    );

    assign o_in_ready  = (r_state == S_IDLE) && (r_qv == 2'b00);
    assign in_acc      = i_in_valid && o_in_ready;
    assign q_move      = r_qv[0] && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign b           = i_in_data.byte_value;
    assign fld_byte    = 32'(b) << {r_pos[1:0], 3'b000};
    assign fit_sum     = 34'(r_nxo) + 34'(r_comp);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_exp     = r_exp;
        n_cur     = r_cur;
        n_nxo     = r_nxo;
        n_fld     = r_fld;
        n_kword   = r_kword;
        n_kterm   = r_kterm;
        n_kpend   = r_kpend;
        n_hdr_bad = r_hdr_bad;
        n_off_ok  = r_off_ok;
        n_comp    = r_comp;
        n_dec     = r_dec;
        n_eod     = r_eod;
        n_qv      = r_qv;
        n_q0      = r_q0;
        n_q1      = r_q1;
        kwr       = '0;
        srch_start = 1'b0;
        if (q_move) begin
            n_q0 = r_q1;
            n_qv = {1'b0, r_qv[1]};
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_eod = i_in_data.end_of_data;
                    if (i_in_data.start_of_pack) begin
                        n_pos     = '0;
                        n_exp     = '0;
                        n_cur     = '0;
                        n_nxo     = '0;
                        n_fld     = '0;
                        n_kword   = '0;
                        n_kterm   = 1'b0;
                        n_kpend   = ST_OK;
                        n_hdr_bad = 1'b0;
                        n_off_ok  = 1'b0;
                        n_comp    = '0;
                        n_dec     = '0;
                        if (r_pack_len < 32'(HEADER_BYTES)) begin
                            n_q0    = mk_verdict(ST_LEN_SHORT, '0);
                            n_qv    = 2'b01;
                            n_phase = PH_IDLE;
                        end else if (r_pack_len > r_max_len) begin
                            n_q0    = mk_verdict(ST_LEN_LONG, '0);
                            n_qv    = 2'b01;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_HDR;
                        end
                    end
                    case (n_phase)
                        PH_HDR: begin
                            if ((n_pos < 8'd8) && (b != magic_byte(n_pos[2:0]))) begin
                                n_hdr_bad = 1'b1;
                            end
                            if (n_pos >= 8'd8) begin
                                n_fld = (n_pos[1:0] == 2'b00) ? fld_byte : (n_fld | fld_byte);
                            end
                            if (n_pos == 8'(HEADER_BYTES - 1)) begin
                                if (n_hdr_bad) begin
                                    n_q0    = mk_verdict(ST_MAGIC, '0);
                                    n_qv    = 2'b01;
                                    n_phase = PH_IDLE;
                                end else if ((n_fld == '0) || (n_fld > 32'(MAX_ENTRIES))) begin
                                    n_q0    = mk_verdict(ST_COUNT, '0);
                                    n_qv    = 2'b01;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_nxo = 33'(HEADER_BYTES)
                                          + 33'(n_fld[6:0]) * 33'(ENTRY_BYTES);
                                    if (n_nxo > {1'b0, r_pack_len}) begin
                                        n_q0    = mk_verdict(ST_INDEX_FIT, '0);
                                        n_qv    = 2'b01;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_exp   = n_fld[6:0];
                                        n_cur   = '0;
                                        n_phase = PH_ENT;
                                        n_pos   = '0;
                                        n_kterm = 1'b0;
                                        n_kpend = ST_OK;
                                    end
                                end
                            end else begin
                                n_pos = n_pos + 8'd1;
                            end
                        end
                        PH_ENT: begin
                            if (r_pos < 8'(KEY_BYTES)) begin
                                if (!r_kterm) begin
                                    if (b == 8'd0) begin
                                        n_kterm = 1'b1;
                                        if (r_pos == 8'd0) begin
                                            n_kpend = ST_KEY_EMPTY;
                                        end
                                    end else if (!key_char_ok(b) && (r_kpend == ST_OK)) begin
                                        n_kpend = ST_KEY_CHAR;
                                    end
                                end else if ((b != 8'd0) && (r_kpend == ST_OK)) begin
                                    n_kpend = ST_KEY_PAD;
                                end
                                n_kword = (r_pos[2:0] == 3'd0)
                                        ? 64'(b)
                                        : (r_kword | (64'(b) << {r_pos[2:0], 3'b000}));
                                if (r_pos[2:0] == 3'd7) begin
                                    kwr.en   = 1'b1;
                                    kwr.addr = {r_cur[ENT_BITS-1:0], r_pos[5:3]};
                                    kwr.data = n_kword;
                                end
                            end else begin
                                n_fld = (r_pos[1:0] == 2'b00) ? fld_byte : (r_fld | fld_byte);
                                if (r_pos == 8'(KEY_BYTES + 3)) begin
                                    n_off_ok = ({1'b0, n_fld} == r_nxo);
                                end
                                if (r_pos == 8'(KEY_BYTES + 7)) begin
                                    n_comp = (n_fld > 32'(COMP_MAX))
                                           ? (COMP_MAX + 17'd1) : n_fld[16:0];
                                end
                                if (r_pos == 8'(KEY_BYTES + 11)) begin
                                    n_dec = (n_fld > 32'(DEC_MAX))
                                          ? (DEC_MAX + 17'd1) : n_fld[16:0];
                                end
                            end
                            if (r_pos == 8'(ENTRY_BYTES - 1)) begin
                                srch_start = 1'b1;
                                n_state    = S_SEARCH;
                            end else begin
                                n_pos = r_pos + 8'd1;
                            end
                        end
                        default: ;
                    endcase
                    if (!srch_start && i_in_data.end_of_data && (n_phase != PH_IDLE)) begin
                        n_q0    = mk_verdict(ST_TRUNC, '0);
                        n_qv    = 2'b01;
                        n_phase = PH_IDLE;
                    end
                end
            end
            S_SEARCH: begin
                if (srch.done) begin
                    n_state = S_IDLE;
                    n_qv    = 2'b01;
                    n_phase = PH_IDLE;
                    if (!r_kterm) begin
                        n_q0 = mk_verdict(ST_KEY_EMPTY, '0);
                    end else if (r_kpend != ST_OK) begin
                        n_q0 = mk_verdict(r_kpend, '0);
                    end else if (srch.dup) begin
                        n_q0 = mk_verdict(ST_KEY_DUP, '0);
                    end else if (!r_off_ok) begin
                        n_q0 = mk_verdict(ST_OFFSET, '0);
                    end else if ((r_comp < COMP_MIN) || (r_comp > COMP_MAX)) begin
                        n_q0 = mk_verdict(ST_COMP_LEN, '0);
                    end else if ((r_dec < DEC_MIN) || (r_dec > DEC_MAX)) begin
                        n_q0 = mk_verdict(ST_DEC_LEN, '0);
                    end else if (fit_sum > 34'(r_pack_len)) begin
                        n_q0 = mk_verdict(ST_COMP_FIT, '0);
                    end else begin
                        n_q0                   = '0;
                        n_q0.status            = ST_OK;
                        n_q0.entry_number      = r_cur[5:0];
                        n_q0.data_offset       = r_nxo[31:0];
                        n_q0.compressed_length = r_comp;
                        n_q0.decoded_length    = r_dec;
                        n_nxo   = r_nxo + 33'(r_comp);
                        n_cur   = r_cur + 7'd1;
                        n_pos   = '0;
                        n_kterm = 1'b0;
                        n_kpend = ST_OK;
                        if (n_cur >= r_exp) begin
                            n_q1 = mk_verdict((n_nxo != {1'b0, r_pack_len}) ? ST_TOTAL : ST_OK,
                                              r_exp);
                            n_qv = 2'b11;
                        end else if (r_eod) begin
                            n_q1 = mk_verdict(ST_TRUNC, '0);
                            n_qv = 2'b11;
                        end else begin
                            n_phase = PH_ENT;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_exp      <= '0;
            r_cur      <= '0;
            r_nxo      <= '0;
            r_fld      <= '0;
            r_kword    <= '0;
            r_kterm    <= 1'b0;
            r_kpend    <= ST_OK;
            r_hdr_bad  <= 1'b0;
            r_off_ok   <= 1'b0;
            r_comp     <= '0;
            r_dec      <= '0;
            r_eod      <= 1'b0;
            r_qv       <= 2'b00;
            r_ov       <= 1'b0;
            r_pack_len <= '0;
            r_max_len  <= '1;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_exp     <= n_exp;
            r_cur     <= n_cur;
            r_nxo     <= n_nxo;
            r_fld     <= n_fld;
            r_kword   <= n_kword;
            r_kterm   <= n_kterm;
            r_kpend   <= n_kpend;
            r_hdr_bad <= n_hdr_bad;
            r_off_ok  <= n_off_ok;
            r_comp    <= n_comp;
            r_dec     <= n_dec;
            r_eod     <= n_eod;
            r_qv      <= n_qv;
            if (q_move) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PACK_LENGTH: r_pack_len <= i_cfg_wdata;
                    CFG_MAX_PACK:    r_max_len  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
        if (q_move) begin
            r_out <= r_q0;
        end
    end

    a_search_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && srch.done) |=> (r_state == S_IDLE))
        else $error("search completion did not return to idle");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qv[1] |-> r_qv[0])
        else $error("second queue slot filled ahead of the first");

    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ENT) |-> (r_cur < r_exp))
        else $error("entry index reached the entry count during a run");

    a_search_queue_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_qv == 2'b00))
        else $error("results queued while a key search runs");

endmodule
